>>> hdl/pvsf_pkg.sv
// Shared types and constants for the prime value stream filter.
`default_nettype none

package pvsf_pkg;

	// Default element width.
	localparam int DATA_WIDTH_DEF = 32;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_TEST = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_EVAL = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture an input word
		logic init_div;  // divisor to two, start a division
		logic step_div;  // one restoring division step
		logic inc_div;   // advance the divisor, restart the division
		logic set_keep;  // write the keep flag
		logic keep_val;  // value for the keep flag
		logic out_load;  // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trivial;   // value is negative, zero or one
		logic div_last;  // this division step is the final one
		logic d_gt_q;    // divisor exceeds the quotient: no divisor left
		logic rem_zero;  // remainder is zero: divisor found
		logic out_free;  // output register can take a result this cycle
	} status_t;

endpackage : pvsf_pkg

`default_nettype wire

>>> hdl/pvsf_dp.sv
// Datapath: element registers, bit-serial divider, divisor and output register.
`default_nettype none

module pvsf_dp
	import pvsf_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output status_t                    sts,
	input  wire logic [DATA_WIDTH-1:0] in_value,
	input  wire logic                  in_last,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [DATA_WIDTH-1:0]      out_value,
	output logic                       out_keep,
	output logic                       out_last
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] value_q;
	logic                  last_q;
	logic                  keep_q;
	logic [DATA_WIDTH-1:0] div_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic                  out_keep_q;
	logic                  out_last_q;

	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;

	assign shifted = {rem_q, quot_q[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_value;
			last_q  <= in_last;
		end
		if (cmd.set_keep) begin
			keep_q <= cmd.keep_val;
		end
		if (cmd.init_div || cmd.inc_div) begin
			div_q  <= cmd.init_div ? DATA_WIDTH'(2) : div_q + DATA_WIDTH'(1);
			rem_q  <= '0;
			quot_q <= value_q;
			cnt_q  <= '0;
		end else if (cmd.step_div) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!diff[DATA_WIDTH]) begin
				rem_q  <= diff[DATA_WIDTH-1:0];
				quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DATA_WIDTH-1:0];
				quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_value_q <= value_q;
			out_keep_q  <= keep_q;
			out_last_q  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.trivial  = value_q[DATA_WIDTH-1] || (value_q <= DATA_WIDTH'(1));
		sts.div_last = (cnt_q == CNT_W'(DATA_WIDTH - 1));
		sts.d_gt_q   = (div_q > quot_q);
		sts.rem_zero = (rem_q == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_keep  = out_keep_q;
	assign out_last  = out_last_q;

	a_out_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("output register not valid after a result load");

	a_no_load_over_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load)
		else $error("result loaded over a word still waiting");

endmodule : pvsf_dp

`default_nettype wire

>>> hdl/pvsf_ctrl.sv
// Controller: sequences capture, trial divisions and result hand-off.
`default_nettype none

module pvsf_ctrl
	import pvsf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sts.trivial) begin
					cmd.set_keep = 1'b1;
					cmd.keep_val = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.init_div = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step_div = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.d_gt_q) begin
					// no divisor up to the square root: prime, drop it
					cmd.set_keep = 1'b1;
					cmd.keep_val = 1'b0;
					state_d      = ST_DONE;
				end else if (sts.rem_zero) begin
					cmd.set_keep = 1'b1;
					cmd.keep_val = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.inc_div = 1'b1;
					state_d     = ST_DIV;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_trivial_skips_division: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST && sts.trivial) |=> (state_q == ST_DONE))
		else $error("trivial value entered the divider");

	a_division_runs_to_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> (state_q == ST_DIV))
		else $error("division left before its final step");

	a_done_waits_for_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> (state_q == ST_DONE))
		else $error("result dropped while output register busy");

endmodule : pvsf_ctrl

`default_nettype wire

>>> hdl/prime_value_stream_filter_core.sv
// Top level of the prime value stream filter: controller plus datapath.
//
// Channel   Dir  Handshake          Contents (lowest bit first)
// s_*       in   s_tvalid/s_tready  tdata: value; tlast: last_in
// m_*       out  m_tvalid/m_tready  tdata: value_out; tuser: keep; tlast: last_out
//
// Each word is captured and tested, then each trial divisor runs a full division
//   and an evaluation, and the result is handed off to the output register. The
//   bit-serial restoring divider, one quotient bit a cycle, dominates the time.
// Values that are negative, zero or one bypass the divider.
// Reset clears the controller state and the output valid flag only.
// A stalled output holds its word; the next input word is taken meanwhile and
//   its result waits in the datapath until the output register frees.
`default_nettype none

module prime_value_stream_filter_core
	import pvsf_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // value
	input  wire logic                                 s_tlast,  // last_in
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]      m_tdata,  // value_out
	output logic                                      m_tuser,  // keep
	output logic                                      m_tlast   // last_out
);

	localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

	cmd_t                  cmd;
	status_t               sts;
	logic [DATA_WIDTH-1:0] out_value;

	// Sequence each word: capture, trivial test, trial divisions, hand-off.
	pvsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the element, run divisions, keep the result register.
	pvsf_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (s_tdata[DATA_WIDTH-1:0]),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (out_value),
		.out_keep  (m_tuser),
		.out_last  (m_tlast)
	);

	// Pad the value up to whole bytes with zeros.
	assign m_tdata = TDATA_W'(out_value);

endmodule : prime_value_stream_filter_core

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the prime value stream filter core.
`timescale 1ns / 100ps

module tb_top;
	import pvsf_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int TW = ((DW + 7) / 8) * 8;
	// The slowest word is a prime near the top of the range.
	localparam int WATCHDOG_LIMIT = 8_000_000;

	typedef struct {
		logic [DW-1:0] value;
		logic          keep;
		logic          last;
	} filter_word_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [TW-1:0] s_tdata;
	logic          s_tlast;
	logic          m_tvalid;
	logic          m_tready;
	logic [TW-1:0] m_tdata;
	logic          m_tuser;
	logic          m_tlast;

	filter_word_t expected_words[$];
	int           mismatches;
	int           quiet_cycles;
	int           stall_left;
	bit           sender_gaps_on;
	bit           sink_stalls_on;

	prime_value_stream_filter_core #(
		.DATA_WIDTH(DW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),    // value
		.s_tlast(s_tlast),    // last_in
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),    // value_out
		.m_tuser(m_tuser),    // keep
		.m_tlast(m_tlast)     // last_out
	);

	always #1 clk = ~clk;

	// Trial division at full width; negative, zero and one are never prime.
	function automatic logic predict_keep(input logic [DW-1:0] value);
		longint unsigned v;
		longint unsigned d;
		v = value;
		if (value[DW-1] || v <= 1) return 1'b1;
		for (d = 2; d <= v / d; d++) begin
			if (v % d == 0) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Check the output word first: it can never belong to a word taken at the same edge.
	always @(posedge clk) begin
		filter_word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected output word: value %0d keep %0b last %0b",
						$signed(m_tdata[DW-1:0]), m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (m_tdata[DW-1:0] !== want.value) begin
						$error("value_out: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata[DW-1:0]));
						mismatches++;
					end
					if (m_tuser !== want.keep) begin
						$error("keep: expected %0b, got %0b (value %0d)",
							want.keep, m_tuser, $signed(want.value));
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("last_out: expected %0b, got %0b (value %0d)",
							want.last, m_tlast, $signed(want.value));
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want.value = s_tdata[DW-1:0];
				want.keep  = predict_keep(s_tdata[DW-1:0]);
				want.last  = s_tlast;
				expected_words.push_back(want);
			end
		end
	end

	// Count cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stall the output side in random bursts.
	always @(negedge clk) begin
		if (sink_stalls_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 6);
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one word, optionally after a gap, and hold it until taken.
	task automatic send_word(input logic [DW-1:0] value, input logic last);
		int gap;
		gap = 0;
		if (sender_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= TW'(value);
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Extremes, trivial values, squares at the divisor bound and the largest prime.
	task automatic test_directed_cases();
		logic [DW-1:0] cases[$];
		cases = '{32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 0, 1, 2, 3, 4, 5, 9, 25,
			49, 97, 121, 10403, 1018081, 65521, 65536, 32'h5555_5555,
			32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF};
		foreach (cases[i]) begin
			send_word(cases[i], (i % 5 == 4) || (i == cases.size() - 1));
		end
	endtask

	// Pick a value: negatives, small and medium magnitudes, large composites,
	// and products of two primes so that the factor sits near the square root.
	function automatic logic [DW-1:0] pick_value();
		int unsigned prime_pool[12] = '{101, 103, 107, 109, 113, 127, 131, 251, 257,
			509, 521, 1021};
		int unsigned factor_pool[5] = '{2, 3, 5, 6, 7};
		int unsigned k;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 25) return $urandom() | 32'h8000_0000;
		if (sel < 60) return $urandom_range(0, 4095);
		if (sel < 75) return $urandom_range(4096, 65535);
		if (sel < 95) begin
			k = factor_pool[$urandom_range(0, 4)];
			return $urandom_range(1, 32'h7FFF_FFFF / k) * k;
		end
		return prime_pool[$urandom_range(0, 11)] * prime_pool[$urandom_range(0, 11)];
	endfunction

	task automatic test_random_mix(input int count);
		repeat (count) send_word(pick_value(), $urandom_range(0, 3) == 0);
	endtask

	// Closing stretch with both sides running flat out.
	task automatic test_back_to_back(input int count);
		sender_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		repeat (count) send_word(pick_value(), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		mismatches     = 0;
		quiet_cycles   = 0;
		stall_left     = 0;
		sender_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_mix(60);
		test_back_to_back(20);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
